[rtl/apo_pkg.sv]
package apo_pkg;

   // Fixed field widths of the item and result formats (signed Q12.12 coordinates).
   localparam int COORD_BITS      = 24;
   localparam int HALF_BITS       = COORD_BITS - 1;
   localparam int STEP_BITS       = 16;
   localparam int ROUNDS_OUT_BITS = 13;

   // Configuration port geometry: seven 32-bit registers at byte addresses 4*i.
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [ROUNDS_OUT_BITS-1:0] ROUNDS_OUT_MAX = {ROUNDS_OUT_BITS{1'b1}};

   // Register reset values: half-extent 1.0 and step 0.1.
   localparam logic [HALF_BITS-1:0] HALF_RESET = HALF_BITS'(4096);
   localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(410);

   // Register indexes.
   localparam logic [2:0] REG_OFFSET_X = 3'd0;
   localparam logic [2:0] REG_OFFSET_Y = 3'd1;
   localparam logic [2:0] REG_OFFSET_Z = 3'd2;
   localparam logic [2:0] REG_HALF_X   = 3'd3;
   localparam logic [2:0] REG_HALF_Y   = 3'd4;
   localparam logic [2:0] REG_HALF_Z   = 3'd5;
   localparam logic [2:0] REG_STEP     = 3'd6;

   // Axis codes used to index the per-axis datapath registers.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] own_x;
      logic signed [COORD_BITS-1:0] own_y;
      logic signed [COORD_BITS-1:0] own_z;
      logic signed [COORD_BITS-1:0] query_x;
      logic signed [COORD_BITS-1:0] query_y;
      logic signed [COORD_BITS-1:0] query_z;
      logic [HALF_BITS-1:0]         query_half_x;
      logic [HALF_BITS-1:0]         query_half_y;
      logic [HALF_BITS-1:0]         query_half_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] resolved_x;
      logic signed [COORD_BITS-1:0] resolved_y;
      logic signed [COORD_BITS-1:0] resolved_z;
      logic                         was_overlapping;
      logic                         gave_up;
      logic [ROUNDS_OUT_BITS-1:0]   rounds_used;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] own_offset_x;
      logic signed [COORD_BITS-1:0] own_offset_y;
      logic signed [COORD_BITS-1:0] own_offset_z;
      logic [HALF_BITS-1:0]         own_half_x;
      logic [HALF_BITS-1:0]         own_half_y;
      logic [HALF_BITS-1:0]         own_half_z;
      logic [STEP_BITS-1:0]         step_amount;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic prep;
      logic diff;
      logic check;
      logic next_probe;
      logic next_round;
      logic hit;
      logic give_up;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear0;
      logic probe_clear;
      logic last_probe;
      logic last_round;
   } status_type;

   // Probe order within a round: x+, x-, z+, z-, y+, y-.
   function automatic logic [1:0] probe_axis(input logic [2:0] idx);
      logic [1:0] ax;
      case (idx[2:1])
         2'd0: ax = AXIS_X;
         2'd1: ax = AXIS_Z;
         default: ax = AXIS_Y;
      endcase
      return ax;
   endfunction

endpackage

[rtl/apo_csr.sv]
module apo_csr
   import apo_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   // Register write decode; writes beyond the last register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_OFFSET_X: cfg_in.own_offset_x = $signed(pwdata[COORD_BITS-1:0]);
            REG_OFFSET_Y: cfg_in.own_offset_y = $signed(pwdata[COORD_BITS-1:0]);
            REG_OFFSET_Z: cfg_in.own_offset_z = $signed(pwdata[COORD_BITS-1:0]);
            REG_HALF_X:   cfg_in.own_half_x   = pwdata[HALF_BITS-1:0];
            REG_HALF_Y:   cfg_in.own_half_y   = pwdata[HALF_BITS-1:0];
            REG_HALF_Z:   cfg_in.own_half_z   = pwdata[HALF_BITS-1:0];
            REG_STEP:     cfg_in.step_amount  = pwdata[STEP_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_offset_x <= '0;
         cfg_ff.own_offset_y <= '0;
         cfg_ff.own_offset_z <= '0;
         cfg_ff.own_half_x   <= HALF_RESET;
         cfg_ff.own_half_y   <= HALF_RESET;
         cfg_ff.own_half_z   <= HALF_RESET;
         cfg_ff.step_amount  <= STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back mux, values zero-extended to the bus width.
   always_comb begin
      case (reg_idx)
         REG_OFFSET_X: prdata = CSR_DATA_BITS'(unsigned'(cfg_ff.own_offset_x));
         REG_OFFSET_Y: prdata = CSR_DATA_BITS'(unsigned'(cfg_ff.own_offset_y));
         REG_OFFSET_Z: prdata = CSR_DATA_BITS'(unsigned'(cfg_ff.own_offset_z));
         REG_HALF_X:   prdata = CSR_DATA_BITS'(cfg_ff.own_half_x);
         REG_HALF_Y:   prdata = CSR_DATA_BITS'(cfg_ff.own_half_y);
         REG_HALF_Z:   prdata = CSR_DATA_BITS'(cfg_ff.own_half_z);
         REG_STEP:     prdata = CSR_DATA_BITS'(cfg_ff.step_amount);
         default: prdata = '0;
      endcase
   end

endmodule

[rtl/apo_ctrl.sv]
module apo_ctrl
   import apo_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type stat,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIFF,
      ST_CHECK,
      ST_PROBE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   assign busy = busy_ff;

   // Sequencing: set up the item, test it unmoved, then one probe per cycle.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.clear0 ? ST_EMIT : ST_PROBE;
         end
         ST_PROBE: begin
            if (stat.probe_clear) begin
               cmd.hit  = 1'b1;
               state_in = ST_EMIT;
            end else if (stat.last_probe) begin
               if (stat.last_round) begin
                  cmd.give_up = 1'b1;
                  state_in    = ST_EMIT;
               end else begin
                  cmd.next_round = 1'b1;
               end
            end else begin
               cmd.next_probe = 1'b1;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

endmodule

[rtl/apo_dp.sv]
module apo_dp
   import apo_pkg::*;
#(
   parameter int MAX_ROUNDS = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  req_type    req,
   input  cmd_type    cmd,
   output status_type stat,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int CB    = COORD_BITS;
   localparam int AW    = CB + 1;                      // own center after offset
   localparam int FW    = CB + 2;                      // center difference
   localparam int RW    = $clog2(MAX_ROUNDS + 1);      // round counter
   localparam int MW    = RW + STEP_BITS;              // probe amount
   localparam int DW    = ((FW > MW + 1) ? FW : MW + 1) + 1;
   localparam int SW    = ((CB > MW) ? CB : MW) + 2;
   localparam int RXW   = (RW > ROUNDS_OUT_BITS) ? RW : ROUNDS_OUT_BITS;

   localparam logic [RW-1:0] LAST_ROUND = RW'(MAX_ROUNDS);

   req_type                req_ff;
   logic signed [AW-1:0]   a_ff     [3];
   logic [CB-1:0]          reach_ff [3];
   logic signed [FW-1:0]   diff_ff  [3];
   logic signed [CB-1:0]   q_w      [3];
   logic                   overlap_ff;
   logic                   found_ff;
   logic                   gave_ff;
   logic [2:0]             idx_ff;
   logic [RW-1:0]          round_ff;
   logic [MW-1:0]          amt_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   logic [1:0]             ax;
   logic signed [DW-1:0]   d_ext;
   logic signed [DW-1:0]   amt_ext;
   logic signed [DW-1:0]   d_probe;
   logic signed [DW-1:0]   reach_ext;
   logic [2:0]             axis_clear0;
   logic signed [SW-1:0]   q_sel_ext;
   logic signed [SW-1:0]   amt_sw;
   logic signed [SW-1:0]   moved;
   logic signed [SW-1:0]   sat_max;
   logic signed [SW-1:0]   sat_min;
   logic signed [CB-1:0]   moved_sat;
   logic [RXW-1:0]         rnd_x;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign q_w[AXIS_X] = req_ff.query_x;
   assign q_w[AXIS_Y] = req_ff.query_y;
   assign q_w[AXIS_Z] = req_ff.query_z;

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
      end
   end

   // Own center with offset, and combined reach per axis.
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         a_ff[AXIS_X] <= $signed({req_ff.own_x[CB-1], req_ff.own_x})
                       + $signed({cfg.own_offset_x[CB-1], cfg.own_offset_x});
         a_ff[AXIS_Y] <= $signed({req_ff.own_y[CB-1], req_ff.own_y})
                       + $signed({cfg.own_offset_y[CB-1], cfg.own_offset_y});
         a_ff[AXIS_Z] <= $signed({req_ff.own_z[CB-1], req_ff.own_z})
                       + $signed({cfg.own_offset_z[CB-1], cfg.own_offset_z});
         reach_ff[AXIS_X] <= {1'b0, req_ff.query_half_x} + {1'b0, cfg.own_half_x};
         reach_ff[AXIS_Y] <= {1'b0, req_ff.query_half_y} + {1'b0, cfg.own_half_y};
         reach_ff[AXIS_Z] <= {1'b0, req_ff.query_half_z} + {1'b0, cfg.own_half_z};
      end
   end

   // Center difference per axis; kept exact so probes never wrap.
   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         for (int i = 0; i < 3; i++) begin
            diff_ff[i] <= $signed({a_ff[i][AW-1], a_ff[i]})
                        - $signed({{(FW-CB){q_w[i][CB-1]}}, q_w[i]});
         end
      end
   end

   // Unmoved test: clear when some axis gap strictly exceeds the reach.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         axis_clear0[i] = (diff_ff[i] > $signed({2'b00, reach_ff[i]}))
                       || (diff_ff[i] < -$signed({2'b00, reach_ff[i]}));
      end
   end

   // One probe per cycle. The unmoved position overlaps on every axis, so a
   // probe is clear exactly when its moved axis is clear.
   always_comb begin
      ax        = probe_axis(idx_ff);
      d_ext     = DW'(diff_ff[ax]);
      amt_ext   = $signed({{(DW-MW){1'b0}}, amt_ff});
      d_probe   = idx_ff[0] ? (d_ext + amt_ext) : (d_ext - amt_ext);
      reach_ext = $signed({{(DW-CB){1'b0}}, reach_ff[ax]});
   end

   assign stat.clear0      = |axis_clear0;
   assign stat.probe_clear = (d_probe > reach_ext) || (d_probe < -reach_ext);
   assign stat.last_probe  = (idx_ff == 3'd5);
   assign stat.last_round  = (round_ff == LAST_ROUND);

   // Search counters and outcome flags.
   always_ff @(posedge clock) begin
      if (cmd.check) begin
         overlap_ff <= ~stat.clear0;
         found_ff   <= 1'b0;
         gave_ff    <= 1'b0;
         idx_ff     <= '0;
         round_ff   <= RW'(1);
         amt_ff     <= MW'(cfg.step_amount);
      end else begin
         if (cmd.next_probe) begin
            idx_ff <= idx_ff + 3'd1;
         end
         if (cmd.next_round) begin
            idx_ff   <= '0;
            round_ff <= round_ff + RW'(1);
            amt_ff   <= amt_ff + MW'(cfg.step_amount);
         end
         if (cmd.hit) begin
            found_ff <= 1'b1;
         end
         if (cmd.give_up) begin
            gave_ff <= 1'b1;
         end
      end
   end

   // Moved coordinate of the winning probe, saturated to the field range.
   always_comb begin
      q_sel_ext = SW'(q_w[ax]);
      amt_sw    = $signed({{(SW-MW){1'b0}}, amt_ff});
      moved     = idx_ff[0] ? (q_sel_ext - amt_sw) : (q_sel_ext + amt_sw);
      sat_max   = $signed({{(SW-CB+1){1'b0}}, {(CB-1){1'b1}}});
      sat_min   = $signed({{(SW-CB+1){1'b1}}, {(CB-1){1'b0}}});
      if (moved > sat_max) begin
         moved_sat = sat_max[CB-1:0];
      end else if (moved < sat_min) begin
         moved_sat = sat_min[CB-1:0];
      end else begin
         moved_sat = moved[CB-1:0];
      end
      rnd_x = RXW'(round_ff);
   end

   // Result formation.
   always_comb begin
      rsp_in.resolved_x      = req_ff.query_x;
      rsp_in.resolved_y      = req_ff.query_y;
      rsp_in.resolved_z      = req_ff.query_z;
      rsp_in.was_overlapping = overlap_ff;
      rsp_in.gave_up         = overlap_ff & gave_ff;
      rsp_in.rounds_used     = '0;
      if (overlap_ff) begin
         rsp_in.rounds_used = (rnd_x > RXW'(ROUNDS_OUT_MAX)) ? ROUNDS_OUT_MAX
                                                             : rnd_x[ROUNDS_OUT_BITS-1:0];
      end
      if (overlap_ff && found_ff) begin
         case (ax)
            AXIS_X: rsp_in.resolved_x = moved_sat;
            AXIS_Y: rsp_in.resolved_y = moved_sat;
            default: rsp_in.resolved_z = moved_sat;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

endmodule

[rtl/aabb_push_out_search.sv]
// Box overlap test with push-out search. An item is taken when start is high
// while busy is low; its result appears on rsp_data for a single cycle with
// rsp_valid high and must be captured then, since the receiver cannot stall.
// The block handles one item at a time: a query that is already clear of the
// own box passes through the prep, diff, check and emit states, and an
// overlapping one also tests probes between check and emit (six per round,
// one per cycle through a single add-and-compare unit, for at most
// MAX_ROUNDS rounds). busy drops in the cycle the result is shown, so the next
// item may be taken in that cycle. Configuration must be written over the
// APB-style port only while the block is idle; the block does not enforce it.
module aabb_push_out_search
   import apo_pkg::*;
#(
   parameter int MAX_ROUNDS = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type stat;

   // Configuration registers.
   apo_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Search sequencer.
   apo_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // Arithmetic and result registers.
   apo_dp #(
      .MAX_ROUNDS (MAX_ROUNDS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/apo_checker.sv]
module apo_checker
   import apo_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // A result strobe lasts one cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A taken item makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item taken but block not busy");

   // The block finishes an item only by showing its result.
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a result");

   // Giving up only happens after an overlapping start.
   a_gave_up_overlap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.gave_up) |-> rsp_data.was_overlapping)
      else $error("gave up on a query that was clear");

   // A clear query needs no rounds.
   a_clear_no_rounds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.was_overlapping) |->
         (rsp_data.rounds_used == '0))
      else $error("clear query reports search rounds");

endmodule

bind aabb_push_out_search apo_checker u_apo_checker (.*);

[verif/push_out_checker.sv]
module push_out_checker
   import apo_pkg::*;
#(
   parameter int MAX_ROUNDS = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  req_type                  req_data,
   input  logic                     rsp_valid,
   input  rsp_type                  rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   input  logic                     pready,
   output int                       mismatch_count,
   output int                       pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint COORD_MAX    = (longint'(1) <<< (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN    = -COORD_MAX - 1;
   localparam int     REPORT_LINES = 30;

   // Probe order within a round: x, then z, then y; plus before minus on each axis.
   localparam logic [1:0] PROBE_ORDER [3] = '{AXIS_X, AXIS_Z, AXIS_Y};

   cfg_type own_box_cfg;
   rsp_type expected_resolutions [$];
   int      result_index;

   // The boxes are apart when some axis has a center gap strictly above the reach.
   function automatic bit boxes_apart(input longint anchor [3], input longint reach [3],
                                      input longint probe [3]);
      longint gap;
      for (int k = 0; k < 3; k++) begin
         gap = anchor[k] - probe[k];
         if (gap < 0) gap = -gap;
         if (gap > reach[k]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [COORD_BITS-1:0] saturate_coord(input longint v);
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      return COORD_BITS'(v);
   endfunction

   // Full push-out search for one item, kept exact in 64 bits until the outputs.
   function automatic rsp_type resolve_push_out(input req_type item, input cfg_type regs);
      longint  anchor [3];
      longint  reach [3];
      longint  query [3];
      longint  probe [3];
      longint  amount;
      int      rounds;
      bit      found;
      bit      overlap;
      rsp_type res;
      anchor[AXIS_X] = longint'($signed(item.own_x)) + longint'($signed(regs.own_offset_x));
      anchor[AXIS_Y] = longint'($signed(item.own_y)) + longint'($signed(regs.own_offset_y));
      anchor[AXIS_Z] = longint'($signed(item.own_z)) + longint'($signed(regs.own_offset_z));
      query[AXIS_X]  = longint'($signed(item.query_x));
      query[AXIS_Y]  = longint'($signed(item.query_y));
      query[AXIS_Z]  = longint'($signed(item.query_z));
      reach[AXIS_X]  = longint'(regs.own_half_x) + longint'(item.query_half_x);
      reach[AXIS_Y]  = longint'(regs.own_half_y) + longint'(item.query_half_y);
      reach[AXIS_Z]  = longint'(regs.own_half_z) + longint'(item.query_half_z);
      probe   = query;
      rounds  = 0;
      found   = 1'b0;
      overlap = !boxes_apart(anchor, reach, query);
      if (overlap) begin
         for (int r = 1; r <= MAX_ROUNDS && !found; r++) begin
            amount = longint'(r) * longint'(regs.step_amount);
            rounds = r;
            for (int i = 0; i < 6 && !found; i++) begin
               probe = query;
               probe[PROBE_ORDER[i / 2]] += (i % 2 == 1) ? -amount : amount;
               found = boxes_apart(anchor, reach, probe);
            end
         end
         // An exhausted search reports the unmoved query.
         if (!found) probe = query;
      end
      res.resolved_x      = saturate_coord(probe[AXIS_X]);
      res.resolved_y      = saturate_coord(probe[AXIS_Y]);
      res.resolved_z      = saturate_coord(probe[AXIS_Z]);
      res.was_overlapping = overlap;
      res.gave_up         = overlap && !found;
      res.rounds_used     = (rounds > int'(ROUNDS_OUT_MAX)) ? ROUNDS_OUT_MAX
                                                            : ROUNDS_OUT_BITS'(rounds);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] seen,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) begin
         $display("%0t ns: result %0d: %s is %h, predicted %h",
                  $realtime, result_index, what, seen, want);
      end
   endtask

   task automatic compare_result(input rsp_type seen, input rsp_type want);
      if (seen.resolved_x !== want.resolved_x)
         report_mismatch("resolved_x", seen.resolved_x, want.resolved_x);
      if (seen.resolved_y !== want.resolved_y)
         report_mismatch("resolved_y", seen.resolved_y, want.resolved_y);
      if (seen.resolved_z !== want.resolved_z)
         report_mismatch("resolved_z", seen.resolved_z, want.resolved_z);
      if (seen.was_overlapping !== want.was_overlapping)
         report_mismatch("was_overlapping", seen.was_overlapping, want.was_overlapping);
      if (seen.gave_up !== want.gave_up)
         report_mismatch("gave_up", seen.gave_up, want.gave_up);
      if (seen.rounds_used !== want.rounds_used)
         report_mismatch("rounds_used", seen.rounds_used, want.rounds_used);
   endtask

   // Results are retired before new items are taken, since the block can take the
   // next item in the cycle that shows the previous result.
   always @(posedge clock) begin
      if (reset) begin
         expected_resolutions.delete();
         own_box_cfg.own_offset_x = '0;
         own_box_cfg.own_offset_y = '0;
         own_box_cfg.own_offset_z = '0;
         own_box_cfg.own_half_x   = HALF_RESET;
         own_box_cfg.own_half_y   = HALF_RESET;
         own_box_cfg.own_half_z   = HALF_RESET;
         own_box_cfg.step_amount  = STEP_RESET;
         mismatch_count           = 0;
         pending_count            = 0;
         result_index             = 0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (expected_resolutions.size() == 0) begin
               report_mismatch("result with no item pending", rsp_data.resolved_x, '0);
            end else begin
               compare_result(rsp_data, expected_resolutions.pop_front());
            end
            result_index++;
         end
         if (start && !busy) begin
            expected_resolutions.push_back(resolve_push_out(req_data, own_box_cfg));
         end
         // Register writes land on the access cycle; unknown indexes are dropped.
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_BITS-1:2])
               REG_OFFSET_X: own_box_cfg.own_offset_x = pwdata[COORD_BITS-1:0];
               REG_OFFSET_Y: own_box_cfg.own_offset_y = pwdata[COORD_BITS-1:0];
               REG_OFFSET_Z: own_box_cfg.own_offset_z = pwdata[COORD_BITS-1:0];
               REG_HALF_X:   own_box_cfg.own_half_x   = pwdata[HALF_BITS-1:0];
               REG_HALF_Y:   own_box_cfg.own_half_y   = pwdata[HALF_BITS-1:0];
               REG_HALF_Z:   own_box_cfg.own_half_z   = pwdata[HALF_BITS-1:0];
               REG_STEP:     own_box_cfg.step_amount  = pwdata[STEP_BITS-1:0];
               default: ;
            endcase
         end
         pending_count = expected_resolutions.size();
      end
   end

endmodule

[verif/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import apo_pkg::*;

   localparam int         MAX_ROUNDS = 4096;
   localparam longint     COORD_MAX  = (longint'(1) <<< (COORD_BITS - 1)) - 1;
   localparam longint     COORD_MIN  = -COORD_MAX - 1;
   localparam longint     HALF_MAX   = (longint'(1) <<< HALF_BITS) - 1;
   localparam longint     STEP_MAX   = (longint'(1) <<< STEP_BITS) - 1;
   // First index past the register list; writes there must be dropped.
   localparam logic [2:0] REG_UNUSED = 3'd7;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   req_type                  req_data;
   logic                     rsp_valid;
   rsp_type                  rsp_data;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;
   int                       mismatch_count;
   int                       pending_count;

   // Stimulus-side copy of the geometry, used only to aim queries at the own box.
   longint cur_offset [3];
   longint cur_half [3];
   int     idle_pct;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   aabb_push_out_search #(
      .MAX_ROUNDS (MAX_ROUNDS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   push_out_checker #(
      .MAX_ROUNDS (MAX_ROUNDS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   function automatic longint rand_coord();
      return longint'($signed(COORD_BITS'($urandom())));
   endfunction

   function automatic req_type box_item(input longint own_x, own_y, own_z,
                                        input longint query_x, query_y, query_z,
                                        input longint half_x, half_y, half_z);
      req_type it;
      it.own_x        = COORD_BITS'(own_x);
      it.own_y        = COORD_BITS'(own_y);
      it.own_z        = COORD_BITS'(own_z);
      it.query_x      = COORD_BITS'(query_x);
      it.query_y      = COORD_BITS'(query_y);
      it.query_z      = COORD_BITS'(query_z);
      it.query_half_x = HALF_BITS'(half_x);
      it.query_half_y = HALF_BITS'(half_y);
      it.query_half_z = HALF_BITS'(half_z);
      return it;
   endfunction

   // Mostly a center within reach of the own box, so the search has work to do.
   function automatic logic [COORD_BITS-1:0] near_coord(input longint anchor,
                                                        input longint reach);
      longint span;
      longint v;
      if ($urandom_range(9) == 0) return COORD_BITS'($urandom());
      span = reach + 2;
      v = anchor + longint'($urandom_range(32'(2 * span))) - span;
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      return COORD_BITS'(v);
   endfunction

   // The x reach bounds the search length, so its query half-extent is kept in
   // check except for noise items, which only run with a large step.
   function automatic req_type make_item(input int qhx_lim, input int qhyz_lim,
                                         input int noise_pct);
      req_type it;
      it.own_x = COORD_BITS'($urandom());
      it.own_y = COORD_BITS'($urandom());
      it.own_z = COORD_BITS'($urandom());
      if ($urandom_range(99) < noise_pct) begin
         it.query_x      = COORD_BITS'($urandom());
         it.query_y      = COORD_BITS'($urandom());
         it.query_z      = COORD_BITS'($urandom());
         it.query_half_x = HALF_BITS'($urandom());
         it.query_half_y = HALF_BITS'($urandom());
         it.query_half_z = HALF_BITS'($urandom());
      end else begin
         it.query_half_x = HALF_BITS'($urandom_range(qhx_lim));
         it.query_half_y = HALF_BITS'($urandom_range(qhyz_lim));
         it.query_half_z = HALF_BITS'($urandom_range(qhyz_lim));
         it.query_x = near_coord(longint'($signed(it.own_x)) + cur_offset[AXIS_X],
                                 cur_half[AXIS_X] + longint'(it.query_half_x));
         it.query_y = near_coord(longint'($signed(it.own_y)) + cur_offset[AXIS_Y],
                                 cur_half[AXIS_Y] + longint'(it.query_half_y));
         it.query_z = near_coord(longint'($signed(it.own_z)) + cur_offset[AXIS_Z],
                                 cur_half[AXIS_Z] + longint'(it.query_half_z));
      end
      return it;
   endfunction

   // One register write: setup cycle, then access cycle; junk in the unused bits.
   task automatic write_field(input logic [2:0] index, input longint value,
                              input int width);
      logic [31:0] mask;
      mask    = (32'h1 << width) - 32'h1;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_BITS'({index, 2'b00});
      pwdata  <= ($urandom() & ~mask) | (32'(value) & mask);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input longint off_x, off_y, off_z,
                            input longint half_x, half_y, half_z, input longint step);
      write_field(REG_OFFSET_X, off_x, COORD_BITS);
      write_field(REG_OFFSET_Y, off_y, COORD_BITS);
      write_field(REG_OFFSET_Z, off_z, COORD_BITS);
      write_field(REG_HALF_X, half_x, HALF_BITS);
      write_field(REG_HALF_Y, half_y, HALF_BITS);
      write_field(REG_HALF_Z, half_z, HALF_BITS);
      write_field(REG_STEP, step, STEP_BITS);
      cur_offset[AXIS_X] = off_x;
      cur_offset[AXIS_Y] = off_y;
      cur_offset[AXIS_Z] = off_z;
      cur_half[AXIS_X]   = half_x;
      cur_half[AXIS_Y]   = half_y;
      cur_half[AXIS_Z]   = half_z;
   endtask

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
   endtask

   // Stop offering items and wait until every result has come back.
   task automatic drain();
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic run_phase(input int n_items, input int qhx_lim, input int qhyz_lim,
                            input int noise_pct);
      repeat (n_items) send_item(make_item(qhx_lim, qhyz_lim, noise_pct));
      drain();
   endtask

   initial begin
      int step;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      idle_pct = 20;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed items at the reset geometry: unit half-extents, step of 0.1.
      send_item(box_item(0, 0, 0, 100000, 0, 0, 0, 0, 0));
      // Touching boxes count as overlapping; one unit further they are apart.
      send_item(box_item(0, 0, 0, 8192, 0, 0, 4096, 4096, 4096));
      send_item(box_item(0, 0, 0, 8193, 0, 0, 4096, 4096, 4096));
      send_item(box_item(0, 0, 0, 0, 0, 0, 4096, 4096, 4096));
      send_item(box_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
      // Directions x-, z+, z-, y+ and y- each win once.
      send_item(box_item(0, 0, 0, -1000, 0, 0, 0, 0, 0));
      send_item(box_item(0, 0, 0, 0, 0, 4000, 100000, 0, 0));
      send_item(box_item(0, 0, 0, 0, 0, -4000, 100000, 0, 0));
      send_item(box_item(0, 0, 0, 0, 4000, 0, 100000, 0, 100000));
      send_item(box_item(0, 0, 0, 0, -4000, 0, 100000, 0, 100000));
      // Probes pushed past the coordinate range saturate at both ends.
      send_item(box_item(COORD_MAX, 0, 0, COORD_MAX, 0, 0, 0, 100000, 100000));
      send_item(box_item(COORD_MIN + 8, 0, 0, COORD_MIN, 0, 0, 0, 100000, 100000));
      send_item(box_item(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                         HALF_MAX, HALF_MAX, HALF_MAX));
      // Full reach on every axis: the search runs out of rounds.
      send_item(box_item(0, 0, 0, 0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX));
      drain();

      // A write past the last register leaves the geometry alone.
      write_field(REG_UNUSED, $urandom(), 32);
      send_item(box_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
      drain();

      // The own center lies beyond the coordinate range and must not wrap.
      configure(COORD_MAX, 0, 0, 4096, 4096, 4096, 410);
      send_item(box_item(COORD_MAX, 0, 0, COORD_MAX, 0, 0, HALF_MAX, 100000, 100000));
      drain();

      // With no step every probe is the unmoved query.
      configure(0, 0, 0, 4096, 4096, 4096, 0);
      send_item(box_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
      drain();

      // Random geometry phases, sender idling 20 percent of the time.
      configure(longint'($urandom_range(131072)) - 65536,
                longint'($urandom_range(131072)) - 65536,
                longint'($urandom_range(131072)) - 65536, 4096, 4096, 4096, 410);
      run_phase(220, 8192, 20000, 0);
      configure(COORD_MAX, COORD_MIN, 0, 0, 100000, HALF_MAX, STEP_MAX);
      run_phase(220, 1 << 20, 1 << 22, 25);

      // Sender idling 74 percent of the time.
      idle_pct = 74;
      configure(0, 0, 0, 5, 0, 17, 1);
      run_phase(220, 60, 60, 0);
      configure(COORD_MIN, COORD_MAX, rand_coord(), HALF_MAX, 0, 0, STEP_MAX);
      run_phase(80, 1 << 22, 1 << 22, 25);

      // Back-to-back items with random geometry scaled to the step.
      idle_pct = 0;
      repeat (2) begin
         step = $urandom_range(4000, 200);
         configure(rand_coord(), rand_coord(), rand_coord(), $urandom_range(16 * step),
                   $urandom_range(1 << 20), $urandom_range(1 << 20), step);
         run_phase(300, 16 * step, 1 << 20, 0);
      end

      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Guard against a hang anywhere in the run.
   initial begin
      #40_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

[files.f]
rtl/apo_pkg.sv
rtl/apo_csr.sv
rtl/apo_ctrl.sv
rtl/apo_dp.sv
rtl/aabb_push_out_search.sv
rtl/apo_checker.sv
verif/push_out_checker.sv
verif/testbench.sv
